// ===== rtl/dssa_pkg.sv =====
// Shared types and constants of the dual stack shared array unit.
`default_nettype none
package dssa_pkg;

  localparam int DepthDefault = 1024;
  localparam int CapW         = 11;
  localparam int DataW        = 32;
  localparam int OpW          = 3;
  localparam int IdxOutW      = 10;
  localparam int CntOutW      = 11;
  localparam int CapReset     = 1024;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef struct packed {
    logic                      status;
    logic signed [DataW-1:0]   data;
    logic [IdxOutW-1:0]        found_index;
    logic [CntOutW-1:0]        count_a;
    logic [CntOutW-1:0]        count_b;
    logic                      empty_a;
    logic                      empty_b;
    logic                      full_res;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/dssa_if.sv =====
// Request, result and configuration channel interfaces.
`default_nettype none
interface dssa_req_if import dssa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          op;
  logic                    side;
  logic signed [DataW-1:0] value;

  modport source (output valid, op, side, value, input ready);
  modport sink   (input valid, op, side, value, output ready);
endinterface

interface dssa_rsp_if import dssa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic signed [DataW-1:0] data;
  logic [IdxOutW-1:0]      found_index;
  logic [CntOutW-1:0]      count_a;
  logic [CntOutW-1:0]      count_b;
  logic                    empty_a;
  logic                    empty_b;
  logic                    full_res;

  modport source (output valid, status, data, found_index, count_a, count_b,
                  empty_a, empty_b, full_res, input ready);
  modport sink   (input valid, status, data, found_index, count_a, count_b,
                  empty_a, empty_b, full_res, output ready);
endinterface

interface dssa_cfg_if import dssa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface
`default_nettype wire

// ===== rtl/dssa_mem.sv =====
// Single-port word store with registered read data.
`default_nettype none
module dssa_mem import dssa_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DataW-1:0]         wdata_i,
  output logic      [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/dssa_ctrl.sv =====
// Sequencer: fill counts, store addressing, search walk and result build.
`default_nettype none
module dssa_ctrl import dssa_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [$clog2(DEPTH+1)-1:0]     cap_i,
  input  wire logic                           clr_i,
  dssa_req_if.sink                            req_i,
  input  wire logic                           out_free_i,
  output logic                                commit_o,
  output rsp_t                                res_o,
  output logic                                mem_we_o,
  output logic                                mem_re_o,
  output logic [$clog2(DEPTH)-1:0]            mem_addr_o,
  output logic [DataW-1:0]                    mem_wdata_o,
  input  wire logic [DataW-1:0]               mem_rdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [OpW-1:0]   op_q;
  logic             side_q;
  logic [DataW-1:0] value_q;
  logic [CW-1:0]    fill_a_q, fill_a_d, fill_b_q, fill_b_d;
  logic [AW-1:0]    scan_idx_q, scan_idx_d;
  logic [CW-1:0]    left_q, left_d;

  logic             accept;
  logic [CW-1:0]    top_in_w, push_w, fill_in, fill_sel;
  logic [CW:0]      sum_q_w, sum_d_w;
  logic             room, done;
  logic [AW-1:0]    next_idx;
  logic [31:0]      cnt_a_ext, cnt_b_ext, idx_ext;
  logic             status_w;
  logic [DataW-1:0] data_w;
  logic [AW-1:0]    found_w;

  assign req_i.ready = state_q[0];
  assign accept      = req_i.valid && state_q == S_IDLE;

  assign fill_in  = req_i.side ? fill_b_q : fill_a_q;
  assign top_in_w = req_i.side ? (cap_i - fill_b_q) : (fill_a_q - CW'(1));
  assign fill_sel = side_q ? fill_b_q : fill_a_q;
  assign push_w   = side_q ? (cap_i - CW'(1) - fill_b_q) : fill_a_q;
  assign sum_q_w  = {1'b0, fill_a_q} + {1'b0, fill_b_q};
  assign room     = sum_q_w < {1'b0, cap_i};
  // A scans downward toward entry 0, B upward toward cap-1
  assign next_idx = side_q ? (scan_idx_q + AW'(1)) : (scan_idx_q - AW'(1));

  always_comb begin
    state_d     = state_q;
    fill_a_d    = fill_a_q;
    fill_b_d    = fill_b_q;
    scan_idx_d  = scan_idx_q;
    left_d      = left_q;
    done        = 1'b0;
    status_w    = 1'b1;
    data_w      = '0;
    found_w     = '0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = top_in_w[AW-1:0];
    mem_wdata_o = value_q;

    case (state_q)
      S_IDLE: begin
        // read the top entry as the item is taken
        mem_re_o = req_i.valid;
        if (accept) begin
          scan_idx_d = top_in_w[AW-1:0];
          left_d     = fill_in;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_e'(op_q))
          OP_PUSH: begin
            done       = 1'b1;
            mem_addr_o = push_w[AW-1:0];
            if (room) begin
              status_w = 1'b0;
              mem_we_o = out_free_i;
              if (side_q) fill_b_d = fill_b_q + CW'(1);
              else        fill_a_d = fill_a_q + CW'(1);
            end
          end
          OP_POP, OP_PEEK: begin
            done = 1'b1;
            if (fill_sel != '0) begin
              status_w = 1'b0;
              data_w   = mem_rdata_i;
              if (op_e'(op_q) == OP_POP) begin
                if (side_q) fill_b_d = fill_b_q - CW'(1);
                else        fill_a_d = fill_a_q - CW'(1);
              end
            end
          end
          OP_CLEAR: begin
            done     = 1'b1;
            status_w = 1'b0;
            if (side_q) fill_b_d = '0;
            else        fill_a_d = '0;
          end
          OP_SEARCH: begin
            // read data belongs to scan_idx_q
            if (left_q == '0) begin
              done = 1'b1;
            end else if (mem_rdata_i == value_q) begin
              done     = 1'b1;
              status_w = 1'b0;
              found_w  = scan_idx_q;
            end else if (left_q == CW'(1)) begin
              done = 1'b1;
            end else begin
              mem_re_o   = 1'b1;
              mem_addr_o = next_idx;
              scan_idx_d = next_idx;
              left_d     = left_q - CW'(1);
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done && out_free_i) begin
          state_d = S_IDLE;
        end else begin
          fill_a_d = fill_a_q;
          fill_b_d = fill_b_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign commit_o  = state_q == S_EXEC && done && out_free_i;
  assign sum_d_w   = {1'b0, fill_a_d} + {1'b0, fill_b_d};
  assign cnt_a_ext = 32'(fill_a_d);
  assign cnt_b_ext = 32'(fill_b_d);
  assign idx_ext   = 32'(found_w);

  always_comb begin
    res_o.status      = status_w;
    res_o.data        = data_w;
    res_o.found_index = idx_ext[IdxOutW-1:0];
    res_o.count_a     = cnt_a_ext[CntOutW-1:0];
    res_o.count_b     = cnt_b_ext[CntOutW-1:0];
    res_o.empty_a     = fill_a_d == '0;
    res_o.empty_b     = fill_b_d == '0;
    res_o.full_res    = sum_d_w >= {1'b0, cap_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_a_q <= '0;
      fill_b_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_i) begin
        fill_a_q <= '0;
        fill_b_q <= '0;
      end else begin
        fill_a_q <= fill_a_d;
        fill_b_q <= fill_b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.op;
      side_q  <= req_i.side;
      value_q <= req_i.value;
    end
    scan_idx_q <= scan_idx_d;
    left_q     <= left_d;
  end

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> !mem_re_o)
    else $error("store written and read in one cycle");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_o |-> out_free_i)
    else $error("result committed into a busy output register");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q_w <= {1'b0, cap_i})
    else $error("stacks hold more than the capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted beat did not start execution");

endmodule
`default_nettype wire

// ===== rtl/dual_stack_shared_array_unit.sv =====
// Two stacks in one shared word store: A grows up from entry 0, B down from
// entry capacity-1.
//
// Channels: req_i takes one request beat (op, side, value); rsp_o returns
// exactly one result beat per request, in order; cfg_i writes the capacity
// register (always ready) and empties both stacks. Write it only while idle.
//
// Timing: the top entry is read from the single-port store in the cycle the
// request beat is taken; the request then executes in the EXEC state and its
// result enters the output register once that register is free. A new request
// is taken only in IDLE, after the last has committed. Search walks one entry
// per cycle through the store port from the top toward the bottom and ends early on a match.
//
// Reset clears both fill counts and sets the capacity to its reset value; the
// store itself is not cleared, an entry's data is only used after a push wrote it.
// While rsp_o is stalled the result waits in the output register; the next
// request is still taken and executed, and its result is held until the
// register frees.
`default_nettype none
module dual_stack_shared_array_unit import dssa_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dssa_cfg_if.sink   cfg_i,
  dssa_req_if.sink   req_i,
  dssa_rsp_if.source rsp_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CapSat = (CapReset > DEPTH) ? DEPTH : CapReset;

  logic [CW-1:0]    cap_q, cap_d;
  logic [31:0]      cap_wr;
  logic             cfg_wr;
  logic             rsp_valid_q;
  rsp_t             rsp_q;
  logic             out_free, commit;
  rsp_t             res;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;
  // capacity in use saturates at the store depth
  assign cap_wr      = 32'(cfg_i.capacity);
  assign cap_d       = (cap_wr > 32'(DEPTH)) ? CW'(DEPTH) : cap_wr[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(CapSat);
    end else if (cfg_wr) begin
      cap_q <= cap_d;
    end
  end

  dssa_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .clr_i       (cfg_wr),
    .req_i       (req_i),
    .out_free_i  (out_free),
    .commit_o    (commit),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  dssa_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.data        = rsp_q.data;
  assign rsp_o.found_index = rsp_q.found_index;
  assign rsp_o.count_a     = rsp_q.count_a;
  assign rsp_o.count_b     = rsp_q.count_b;
  assign rsp_o.empty_a     = rsp_q.empty_a;
  assign rsp_o.empty_b     = rsp_q.empty_b;
  assign rsp_o.full_res    = rsp_q.full_res;

endmodule
`default_nettype wire

// ===== tb/sv/tb_dual_stack_shared_array_unit.sv =====
// Testbench for the dual stack shared array unit: directed table, then random requests.
module tb_dual_stack_shared_array_unit;
  import dssa_pkg::*;

  localparam int DEPTH       = DepthDefault;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 37;
  localparam int NUM_PHASES  = 9;
  localparam int REPORT_MAX  = 10;
  localparam int SETTLE      = 20;
  // op codes the block has no operation for
  localparam logic [OpW-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OpW-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    bit               is_cap_write;
    logic [CapW-1:0]  cap;
    logic [OpW-1:0]   op;
    logic             side;
    logic [DataW-1:0] value;
    bit               typed;
    rsp_t             exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  dssa_cfg_if cfg_if ();
  dssa_req_if req_if ();
  dssa_rsp_if rsp_if ();

  dual_stack_shared_array_unit #(.DEPTH(DEPTH)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the block state
  logic [DataW-1:0] shadow_words [DEPTH];
  int unsigned      shadow_fill_a;
  int unsigned      shadow_fill_b;
  logic [CapW-1:0]  shadow_capacity;

  rsp_t pending_results [$];
  bit   idle_on;
  int   mismatch_count  = 0;
  int   cycle_count     = 0;
  int   n_requests      = 0;
  int   n_checked       = 0;
  int   n_push_rejected = 0;
  int   n_search_hits   = 0;
  int   n_cap_writes    = 0;

  int unsigned phase_cap [NUM_PHASES] = '{16, 3, 64, 1, 2047, 33, 0, 1024, 7};
  int unsigned phase_len [NUM_PHASES] = '{190, 110, 190, 50, 40, 190, 20, 40, 70};
  logic [DataW-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005,
                                       32'h0000_002A, 32'hDEAD_BEEF};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Executes one request on the shadow state and returns its result.
  function automatic rsp_t apply_stack_op(input logic [OpW-1:0] op, input logic side,
                                          input logic [DataW-1:0] value);
    rsp_t        r;
    int unsigned cap_used;
    int unsigned fill;
    int unsigned slot;
    cap_used = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    fill     = side ? shadow_fill_b : shadow_fill_a;
    r        = '0;
    r.status = 1'b1;
    case (op)
      OP_PUSH: begin
        if (shadow_fill_a + shadow_fill_b < cap_used) begin
          if (side) begin
            shadow_words[cap_used - 1 - shadow_fill_b] = value;
            shadow_fill_b++;
          end else begin
            shadow_words[shadow_fill_a] = value;
            shadow_fill_a++;
          end
          r.status = 1'b0;
        end else begin
          n_push_rejected++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (fill != 0) begin
          slot     = side ? cap_used - fill : fill - 1;
          r.data   = shadow_words[slot];
          r.status = 1'b0;
          if (op == OP_POP) begin
            if (side) shadow_fill_b--;
            else shadow_fill_a--;
          end
        end
      end
      OP_CLEAR: begin
        if (side) shadow_fill_b = 0;
        else shadow_fill_a = 0;
        r.status = 1'b0;
      end
      OP_SEARCH: begin
        // top toward bottom, first match wins
        for (int unsigned i = 0; i < fill && r.status; i++) begin
          slot = side ? cap_used - fill + i : fill - 1 - i;
          if (shadow_words[slot] == value) begin
            r.found_index = slot[IdxOutW-1:0];
            r.status      = 1'b0;
            n_search_hits++;
          end
        end
      end
      default: ;
    endcase
    r.count_a  = shadow_fill_a[CntOutW-1:0];
    r.count_b  = shadow_fill_b[CntOutW-1:0];
    r.empty_a  = (shadow_fill_a == 0);
    r.empty_b  = (shadow_fill_b == 0);
    r.full_res = (shadow_fill_a + shadow_fill_b >= cap_used);
    return r;
  endfunction

  function automatic dir_row_t req_row(input logic [OpW-1:0] op, input logic side,
                                       input logic [DataW-1:0] value);
    dir_row_t row;
    row       = '{default: '0};
    row.op    = op;
    row.side  = side;
    row.value = value;
    return row;
  endfunction

  function automatic dir_row_t checked_row(input logic [OpW-1:0] op, input logic side,
                                           input logic [DataW-1:0] value, input logic st,
                                           input logic [DataW-1:0] data, input int idx,
                                           input int ca, input int cb, input logic ea,
                                           input logic eb, input logic fr);
    dir_row_t row;
    row                 = req_row(op, side, value);
    row.typed           = 1'b1;
    row.exp.status      = st;
    row.exp.data        = data;
    row.exp.found_index = IdxOutW'(idx);
    row.exp.count_a     = CntOutW'(ca);
    row.exp.count_b     = CntOutW'(cb);
    row.exp.empty_a     = ea;
    row.exp.empty_b     = eb;
    row.exp.full_res    = fr;
    return row;
  endfunction

  function automatic dir_row_t cap_row(input logic [CapW-1:0] cap);
    dir_row_t row;
    row              = '{default: '0};
    row.is_cap_write = 1'b1;
    row.cap          = cap;
    return row;
  endfunction

  task automatic send_request(input logic [OpW-1:0] op, input logic side,
                              input logic [DataW-1:0] value, input bit typed,
                              input rsp_t typed_exp);
    rsp_t predicted;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.side  <= side;
    req_if.value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = apply_stack_op(op, side, value);
    pending_results.push_back(typed ? typed_exp : predicted);
    n_requests++;
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    drain_requests();
    repeat (4) @(negedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk_i); while (!cfg_if.ready);
    shadow_capacity = cap;
    shadow_fill_a   = 0;
    shadow_fill_b   = 0;
    n_cap_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : result_ready
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_results
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status      = rsp_if.status;
      got.data        = rsp_if.data;
      got.found_index = rsp_if.found_index;
      got.count_a     = rsp_if.count_a;
      got.count_b     = rsp_if.count_b;
      got.empty_a     = rsp_if.empty_a;
      got.empty_b     = rsp_if.empty_b;
      got.full_res    = rsp_if.full_res;
      n_checked++;
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("ERROR: result beat %0d with nothing pending: %p", n_checked, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("ERROR: result %0d (exp/act) status %b/%b data %h/%h idx %0d/%0d",
                     n_checked, want.status, got.status, want.data, got.data,
                     want.found_index, got.found_index);
            $display("  cnt_a %0d/%0d cnt_b %0d/%0d empty_a %b/%b empty_b %b/%b full %b/%b",
                     want.count_a, got.count_a, want.count_b, got.count_b,
                     want.empty_a, got.empty_a, want.empty_b, got.empty_b,
                     want.full_res, got.full_res);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t         rows [$];
    logic [OpW-1:0]   op;
    logic             side;
    logic [DataW-1:0] value;
    int unsigned      pick;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.op       = OP_PUSH;
    req_if.side     = 1'b0;
    req_if.value    = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.capacity = CapW'(CapReset);
    shadow_capacity = CapW'(CapReset);
    shadow_fill_a   = 0;
    shadow_fill_b   = 0;
    idle_on         = 1'b1;

    // empty stacks after reset
    rows.push_back(checked_row(OP_POP, 1'b0, '0, 1'b1, '0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    rows.push_back(checked_row(OP_PEEK, 1'b1, '0, 1'b1, '0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    rows.push_back(checked_row(OP_SEARCH, 1'b0, '0, 1'b1, '0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    rows.push_back(checked_row(OP_PUSH, 1'b0, 32'h7FFF_FFFF, 1'b0, '0, 0, 1, 0,
                               1'b0, 1'b1, 1'b0));
    rows.push_back(checked_row(OP_PUSH, 1'b1, 32'h8000_0000, 1'b0, '0, 0, 1, 1,
                               1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_PEEK, 1'b0, '0, 1'b0, 32'h7FFF_FFFF, 0, 1, 1,
                               1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_PEEK, 1'b1, '0, 1'b0, 32'h8000_0000, 0, 1, 1,
                               1'b0, 1'b0, 1'b0));
    // B bottom sits at the last entry
    rows.push_back(checked_row(OP_SEARCH, 1'b1, 32'h8000_0000, 1'b0, '0, 1023, 1, 1,
                               1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_SEARCH, 1'b0, 32'h7FFF_FFFF, 1'b0, '0, 0, 1, 1,
                               1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_SEARCH, 1'b0, '0, 1'b1, '0, 0, 1, 1, 1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_UNUSED_LO, 1'b0, 32'hFFFF_FFFF, 1'b1, '0, 0, 1, 1,
                               1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_UNUSED_HI, 1'b1, '0, 1'b1, '0, 0, 1, 1, 1'b0, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_POP, 1'b0, '0, 1'b0, 32'h7FFF_FFFF, 0, 0, 1,
                               1'b1, 1'b0, 1'b0));
    rows.push_back(checked_row(OP_CLEAR, 1'b1, '0, 1'b0, '0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    // two entries: tops meet
    rows.push_back(cap_row(11'd2));
    rows.push_back(checked_row(OP_PUSH, 1'b0, 32'hFFFF_FFFF, 1'b0, '0, 0, 1, 0,
                               1'b0, 1'b1, 1'b0));
    rows.push_back(checked_row(OP_PUSH, 1'b1, '0, 1'b0, '0, 0, 1, 1, 1'b0, 1'b0, 1'b1));
    rows.push_back(checked_row(OP_PUSH, 1'b0, 32'h5, 1'b1, '0, 0, 1, 1, 1'b0, 1'b0, 1'b1));
    rows.push_back(checked_row(OP_PUSH, 1'b1, 32'h5, 1'b1, '0, 0, 1, 1, 1'b0, 1'b0, 1'b1));
    rows.push_back(checked_row(OP_POP, 1'b1, '0, 1'b0, '0, 0, 1, 0, 1'b0, 1'b1, 1'b0));
    rows.push_back(checked_row(OP_SEARCH, 1'b0, 32'hFFFF_FFFF, 1'b0, '0, 0, 1, 0,
                               1'b0, 1'b1, 1'b0));
    // zero capacity: always full, nothing fits
    rows.push_back(cap_row(11'd0));
    rows.push_back(checked_row(OP_PUSH, 1'b0, 32'h1, 1'b1, '0, 0, 0, 0, 1'b1, 1'b1, 1'b1));
    rows.push_back(checked_row(OP_POP, 1'b1, '0, 1'b1, '0, 0, 0, 0, 1'b1, 1'b1, 1'b1));
    // capacity above the store depth saturates
    rows.push_back(cap_row(11'd2047));
    rows.push_back(req_row(OP_PUSH, 1'b1, 32'h1234_5678));
    rows.push_back(req_row(OP_SEARCH, 1'b1, 32'h1234_5678));
    rows.push_back(req_row(OP_PEEK, 1'b1, '0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].is_cap_write) write_capacity(rows[k].cap);
      else send_request(rows[k].op, rows[k].side, rows[k].value, rows[k].typed, rows[k].exp);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(CapW'(phase_cap[p]));
      idle_on = (p != 2);
      for (int n = 0; n < phase_len[p]; n++) begin
        if ($urandom_range(59) == 0) drain_requests();
        pick = $urandom_range(99);
        if (pick < 40) op = OP_PUSH;
        else if (pick < 58) op = OP_POP;
        else if (pick < 68) op = OP_PEEK;
        else if (pick < 88) op = OP_SEARCH;
        else if (pick < 93) op = OP_CLEAR;
        else op = OpW'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        side  = 1'($urandom_range(1));
        // pool values make search hits common
        value = ($urandom_range(9) < 6) ? value_pool[$urandom_range(7)] : $urandom;
        send_request(op, side, value, 1'b0, '0);
      end
    end

    idle_on = 1'b1;
    drain_requests();
    repeat (SETTLE) @(posedge clk_i);

    $display("Run covered %0d requests across %0d capacity writes, %0d result beats checked",
             n_requests, n_cap_writes, n_checked);
    $display("Pushes refused when full: %0d, search matches: %0d, mismatches: %0d",
             n_push_rejected, n_search_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== dual_stack_shared_array_unit.f =====
rtl/dssa_pkg.sv
rtl/dssa_if.sv
rtl/dssa_mem.sv
rtl/dssa_ctrl.sv
rtl/dual_stack_shared_array_unit.sv
tb/sv/tb_dual_stack_shared_array_unit.sv
